>>> rtl/core/tpr_pkg.sv
`default_nettype none

package tpr_pkg;

    // word and table geometry
    localparam int COLOR_W           = 16;
    localparam int INDEX_W           = 8;
    localparam int THEME_W           = 2;
    localparam int ACTION_W          = 3;
    localparam int THEME_COUNT       = 2;
    localparam int ENTRIES_PER_THEME = 256;
    localparam int STORE_DEPTH       = THEME_COUNT * ENTRIES_PER_THEME;
    localparam int ADDR_W            = $clog2(STORE_DEPTH);

    // bit 15 marks a direct colour, a reference keeps its low byte
    localparam int                 DIRECT_BIT = COLOR_W - 1;
    localparam logic [COLOR_W-1:0] REF_MASK   = 16'h00FF;

    // default length of the hop counter
    localparam int HOP_COUNTER_START_DEF = 5;

    // action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_RESOLVE = 3'd0,
        ACT_WRITE   = 3'd1,
        ACT_SELECT  = 3'd2,
        ACT_TOGGLE  = 3'd3,
        ACT_QUERY   = 3'd4
    } action_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic read;
        logic take;
        logic kill;
        logic finish;
    } tpr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_is_resolve;
        logic chain_stop;
        logic hop_last;
        logic slot_free;
    } tpr_status_t;

endpackage

`default_nettype wire

>>> rtl/core/tpr_ram.sv
`default_nettype none

module tpr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tpr_datapath.sv
`default_nettype none

module tpr_datapath #(
    parameter int HOP_COUNTER_START = tpr_pkg::HOP_COUNTER_START_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tpr_pkg::tpr_cmd_t             cmd,
    output tpr_pkg::tpr_status_t               status,
    input  wire logic [tpr_pkg::ACTION_W-1:0]  action,
    input  wire logic [tpr_pkg::THEME_W-1:0]   theme_number,
    input  wire logic [tpr_pkg::INDEX_W-1:0]   entry_index,
    input  wire logic [tpr_pkg::COLOR_W-1:0]   color_value,
    input  wire logic                          clear_flag,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [tpr_pkg::COLOR_W-1:0]   color_out,
    output logic                               accepted,
    output logic                               changed_out,
    output logic                               theme_out
);

    import tpr_pkg::*;

    localparam int HOP_W = $clog2(HOP_COUNTER_START + 1);

    // captured word
    logic [ACTION_W-1:0] act_reg;
    logic [THEME_W-1:0]  theme_reg;
    logic [INDEX_W-1:0]  idx_reg;
    logic [COLOR_W-1:0]  word_reg;
    logic                clr_reg;

    // chain walk
    logic [COLOR_W-1:0]  c_reg;
    logic [HOP_W-1:0]    hops_reg;
    logic [COLOR_W-1:0]  rdata;

    // block state and result word
    logic                active_reg, active_next;
    logic                changed_reg, changed_next;
    logic                report_next;
    logic                acc_next;
    logic [COLOR_W-1:0]  color_next;
    logic                out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0]  color_out_reg;
    logic                accepted_reg;
    logic                changed_out_reg;
    logic                theme_out_reg;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ADDR_W-1:0]   ram_raddr;

    // palette tables, theme bit on top of the entry index
    assign ram_we    = cmd.finish && (act_reg == ACT_WRITE) && !theme_reg[1];
    assign ram_waddr = {theme_reg[0], idx_reg};
    assign ram_raddr = {active_reg, c_reg[INDEX_W-1:0]};

    tpr_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (word_reg),
        .re    (cmd.read),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    // status back to the controller
    assign status.in_is_resolve = (action == ACT_RESOLVE);
    assign status.chain_stop    = (c_reg == '0) || c_reg[DIRECT_BIT];
    assign status.hop_last      = (hops_reg == HOP_W'(1));
    assign status.slot_free     = !out_valid_reg || out_ready;

    // effect of the held word on theme, flag and result
    always_comb
    begin
        active_next  = active_reg;
        changed_next = changed_reg;
        acc_next     = 1'b1;
        color_next   = '0;
        case (act_reg)
            ACT_RESOLVE:
            begin
                color_next = c_reg;
            end
            ACT_WRITE:
            begin
                if (theme_reg[1])
                begin
                    acc_next = 1'b0;
                end
                else if (theme_reg[0] == active_reg)
                begin
                    changed_next = 1'b1;
                end
            end
            ACT_SELECT:
            begin
                if (theme_reg[1])
                begin
                    acc_next = 1'b0;
                end
                else if (theme_reg[0] != active_reg)
                begin
                    active_next  = theme_reg[0];
                    changed_next = 1'b1;
                end
            end
            ACT_TOGGLE:
            begin
                active_next  = !active_reg;
                changed_next = 1'b1;
            end
            default:
            begin
            end
        endcase
        report_next = changed_next;
        if ((act_reg == ACT_QUERY) && clr_reg)
        begin
            changed_next = 1'b0;
        end
    end

    // output slot occupancy
    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            changed_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.finish)
            begin
                active_reg  <= active_next;
                changed_reg <= changed_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= action;
            theme_reg <= theme_number;
            idx_reg   <= entry_index;
            word_reg  <= color_value;
            clr_reg   <= clear_flag;
            hops_reg  <= HOP_W'(HOP_COUNTER_START);
            if (color_value[DIRECT_BIT])
            begin
                c_reg <= color_value;
            end
            else
            begin
                c_reg <= color_value & REF_MASK;
            end
        end
        else if (cmd.read)
        begin
            hops_reg <= hops_reg - HOP_W'(1);
        end
        else if (cmd.take)
        begin
            c_reg <= rdata;
        end
        else if (cmd.kill)
        begin
            c_reg <= '0;
        end
        if (cmd.finish)
        begin
            color_out_reg   <= color_next;
            accepted_reg    <= acc_next;
            changed_out_reg <= report_next;
            theme_out_reg   <= active_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign color_out   = color_out_reg;
    assign accepted    = accepted_reg;
    assign changed_out = changed_out_reg;
    assign theme_out   = theme_out_reg;

    // a lookup always leaves at least one hop in hand
    a_read_hops: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read |-> (hops_reg > HOP_W'(1)))
        else $error("lookup issued with hop counter exhausted");

    // read data is taken only the cycle after its read
    a_take_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |-> $past(cmd.read))
        else $error("read data taken without a read");

    // the chain is cut only when it would otherwise continue
    a_kill_cond: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.kill |-> (status.hop_last && !status.chain_stop))
        else $error("chain cut while still in budget or already ended");

    // a result appears only from a finish
    a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.finish))
        else $error("result shown without finish");

endmodule

`default_nettype wire

>>> rtl/core/tpr_ctrl.sv
`default_nettype none

module tpr_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire tpr_pkg::tpr_status_t status,
    output tpr_pkg::tpr_cmd_t         cmd
);

    import tpr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WAIT,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.in_is_resolve ? ST_CHECK : ST_FINISH;
                end
            end
            ST_CHECK:
            begin
                if (status.chain_stop)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.hop_last)
                begin
                    cmd.kill   = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.read   = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                cmd.take   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_FINISH:
            begin
                if (status.slot_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

>>> rtl/core/themed_palette_resolver.sv
// themed palette resolver
// input channel in_valid/in_ready carries one command word: action, theme_number,
// entry_index, color_value and clear_flag. output channel out_valid/out_ready
// carries one result word per command: color_out, accepted, changed_out, theme_out.
// a command is taken when in_valid and in_ready are both high at a clock edge.
// non-resolve commands: after acceptance the block waits in its finish step
// until the output slot is free, then loads the result register; a new command is
// taken only after that. resolve: the chain is followed through n table lookups,
// n at most HOP_COUNTER_START-1; each lookup reads the palette ram, then takes the
// registered data. the output register frees the input side: the next command is
// taken while a result still waits; if the receiver stalls, the following command
// holds in its final step until the output slot is free.
// reset (rst_n low, asynchronous) selects theme 0 and sets the changed flag.
// the palette ram is not cleared: the user must write both tables before any
// resolve; the block itself does not enforce this.

`default_nettype none

module themed_palette_resolver #(
    parameter int HOP_COUNTER_START = tpr_pkg::HOP_COUNTER_START_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [tpr_pkg::ACTION_W-1:0]  action,
    input  wire logic [tpr_pkg::THEME_W-1:0]   theme_number,
    input  wire logic [tpr_pkg::INDEX_W-1:0]   entry_index,
    input  wire logic [tpr_pkg::COLOR_W-1:0]   color_value,
    input  wire logic                          clear_flag,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [tpr_pkg::COLOR_W-1:0]   color_out,
    output logic                               accepted,
    output logic                               changed_out,
    output logic                               theme_out
);

    import tpr_pkg::*;

    tpr_cmd_t    cmd;
    tpr_status_t status;

    // sequencer
    tpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // tables, theme state and output register
    tpr_datapath #(
        .HOP_COUNTER_START (HOP_COUNTER_START)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .action       (action),
        .theme_number (theme_number),
        .entry_index  (entry_index),
        .color_value  (color_value),
        .clear_flag   (clear_flag),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .color_out    (color_out),
        .accepted     (accepted),
        .changed_out  (changed_out),
        .theme_out    (theme_out)
    );

endmodule

`default_nettype wire

>>> tb/tb_themed_palette_resolver.sv
`default_nettype none

module tb_themed_palette_resolver;

    import tpr_pkg::*;

    // spare action codes and theme numbers
    localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;
    localparam logic [THEME_W-1:0]  THEME_ZERO      = 2'd0;
    localparam logic [THEME_W-1:0]  THEME_ONE       = 2'd1;
    localparam logic [THEME_W-1:0]  THEME_BAD_LO    = 2'd2;
    localparam logic [THEME_W-1:0]  THEME_BAD_HI    = 2'd3;

    localparam int HOP_START    = HOP_COUNTER_START_DEF;
    localparam int RANDOM_WORDS = 1400;
    localparam int IDLE_PERCENT = 38;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AFTER   = 900;
    localparam int DRAIN_CYCLES = 30;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [THEME_W-1:0]  theme_no;
        logic [INDEX_W-1:0]  index;
        logic [COLOR_W-1:0]  word;
        logic                clr;
    } command_t;

    typedef struct {
        logic [COLOR_W-1:0] colour;
        logic               acc;
        logic               chg;
        logic               theme;
    } reply_t;

    // mirror of the palette state and the replies still owed by the block
    class palette_tracker;
        logic [COLOR_W-1:0] table_mem [STORE_DEPTH];
        bit                 written   [STORE_DEPTH];
        logic               active;
        logic               changed;
        reply_t             awaited [$];
        int                 failures;
        int                 replies_seen;

        function new();
            foreach (written[i])
                written[i] = 1'b0;
            active       = 1'b0;
            changed      = 1'b1;
            failures     = 0;
            replies_seen = 0;
        endfunction

        // follow references through the active theme
        function logic [COLOR_W-1:0] resolve_colour(logic [COLOR_W-1:0] ref_word);
            logic [COLOR_W-1:0] c;
            int                 hops;
            c    = ref_word;
            hops = HOP_START;
            if (!c[DIRECT_BIT])
                c = c & REF_MASK;
            while (c != '0 && !c[DIRECT_BIT])
            begin
                hops--;
                if (hops == 0)
                    c = '0;
                else
                    c = table_mem[{active, c[INDEX_W-1:0]}];
            end
            return c;
        endfunction

        // first entry on the chain that was never written, or -1
        function int first_blank_hop(logic [COLOR_W-1:0] ref_word);
            logic [COLOR_W-1:0] c;
            int                 hops;
            c    = ref_word;
            hops = HOP_START;
            if (!c[DIRECT_BIT])
                c = c & REF_MASK;
            while (c != '0 && !c[DIRECT_BIT])
            begin
                hops--;
                if (hops == 0)
                    return -1;
                if (!written[{active, c[INDEX_W-1:0]}])
                    return int'(c[INDEX_W-1:0]);
                c = table_mem[{active, c[INDEX_W-1:0]}];
            end
            return -1;
        endfunction

        // accepted command word: update state, queue the reply it owes
        function void take_command(command_t c);
            reply_t r;
            r.colour = '0;
            r.acc    = 1'b1;
            case (c.action)
                ACT_RESOLVE:
                    r.colour = resolve_colour(c.word);
                ACT_WRITE:
                    if (c.theme_no > THEME_ONE)
                        r.acc = 1'b0;
                    else
                    begin
                        table_mem[{c.theme_no[0], c.index}] = c.word;
                        written[{c.theme_no[0], c.index}]   = 1'b1;
                        if (c.theme_no[0] == active)
                            changed = 1'b1;
                    end
                ACT_SELECT:
                    if (c.theme_no > THEME_ONE)
                        r.acc = 1'b0;
                    else if (c.theme_no[0] != active)
                    begin
                        active  = c.theme_no[0];
                        changed = 1'b1;
                    end
                ACT_TOGGLE:
                begin
                    active  = ~active;
                    changed = 1'b1;
                end
                default:
                    ;
            endcase
            r.chg = changed;
            if (c.action == ACT_QUERY && c.clr)
                changed = 1'b0;
            r.theme = active;
            awaited.push_back(r);
        endfunction

        // result word from the block against the oldest reply owed
        function void check_result(reply_t got);
            reply_t want;
            replies_seen++;
            if (awaited.size() == 0)
            begin
                $error("result word with nothing outstanding");
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (got.colour !== want.colour)
            begin
                $error("color_out: expected %h, got %h", want.colour, got.colour);
                failures++;
            end
            if (got.acc !== want.acc)
            begin
                $error("accepted: expected %b, got %b", want.acc, got.acc);
                failures++;
            end
            if (got.chg !== want.chg)
            begin
                $error("changed_out: expected %b, got %b", want.chg, got.chg);
                failures++;
            end
            if (got.theme !== want.theme)
            begin
                $error("theme_out: expected %b, got %b", want.theme, got.theme);
                failures++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [ACTION_W-1:0] action;
    logic [THEME_W-1:0]  theme_number;
    logic [INDEX_W-1:0]  entry_index;
    logic [COLOR_W-1:0]  color_value;
    logic                clear_flag;
    logic                out_valid;
    logic                out_ready;
    logic [COLOR_W-1:0]  color_out;
    logic                accepted;
    logic                changed_out;
    logic                theme_out;

    palette_tracker tracker;
    bit             calm;
    bit             hold_done;
    int unsigned    cycle_count;

    themed_palette_resolver #(
        .HOP_COUNTER_START (HOP_START)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .theme_number (theme_number),
        .entry_index  (entry_index),
        .color_value  (color_value),
        .clear_flag   (clear_flag),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .color_out    (color_out),
        .accepted     (accepted),
        .changed_out  (changed_out),
        .theme_out    (theme_out)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // colour word for stores and references, biased towards a small pool
    function automatic logic [COLOR_W-1:0] pick_word();
        int                 k;
        logic [COLOR_W-1:0] w;
        k = $urandom_range(0, 99);
        if (k < 35)
            w = {1'b1, 15'($urandom)};
        else if (k < 75)
        begin
            w = 16'($urandom_range(1, 15));
            if ($urandom_range(0, 3) == 0)
                w[14:8] = 7'($urandom);
        end
        else if (k < 85)
            w = '0;
        else
            w = 16'($urandom);
        return w;
    endfunction

    function automatic logic [INDEX_W-1:0] pick_index();
        if ($urandom_range(0, 99) < 85)
            return 8'($urandom_range(0, 15));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic bit idle_now();
        return !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
    endfunction

    // offer one command word and hold it until taken
    task automatic send_word(command_t c);
        @(negedge clk);
        while (idle_now())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        action       <= c.action;
        theme_number <= c.theme_no;
        entry_index  <= c.index;
        color_value  <= c.word;
        clear_flag   <= c.clr;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.take_command(c);
    endtask

    // a resolve that would touch a blank entry becomes a write of that entry
    task automatic issue(logic [ACTION_W-1:0] act, logic [THEME_W-1:0] th,
                         logic [INDEX_W-1:0] idx, logic [COLOR_W-1:0] w, logic clr);
        command_t c;
        int       blank;
        c.action   = act;
        c.theme_no = th;
        c.index    = idx;
        c.word     = w;
        c.clr      = clr;
        if (act == ACT_RESOLVE)
        begin
            blank = tracker.first_blank_hop(w);
            if (blank >= 0)
            begin
                c.action   = ACT_WRITE;
                c.theme_no = {1'b0, tracker.active};
                c.index    = 8'(blank);
                c.word     = pick_word();
            end
        end
        send_word(c);
    endtask

    // receiver: random stalls, one long hold-off
    initial
    begin
        out_ready = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && tracker.replies_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD)
                    @(negedge clk);
            end
            else
                out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        reply_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.colour = color_out;
            got.acc    = accepted;
            got.chg    = changed_out;
            got.theme  = theme_out;
            tracker.check_result(got);
        end
    end

    // stimulus
    initial
    begin
        int                  n;
        int                  k;
        logic [ACTION_W-1:0] act;
        logic [THEME_W-1:0]  th;

        tracker      = new();
        calm         = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = ACT_RESOLVE;
        theme_number = THEME_ZERO;
        entry_index  = '0;
        color_value  = '0;
        clear_flag   = 1'b0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // flag after reset, query with and without clear
        issue(ACT_QUERY, THEME_ZERO, 8'h00, 16'h0000, 1'b0);
        issue(ACT_QUERY, THEME_ZERO, 8'h00, 16'h0000, 1'b1);
        issue(ACT_QUERY, THEME_ZERO, 8'h00, 16'h0000, 1'b0);
        // write to the active theme raises the flag, to the other does not
        issue(ACT_WRITE, THEME_ZERO, 8'h01, 16'h8000, 1'b0);
        issue(ACT_QUERY, THEME_ZERO, 8'h00, 16'h0000, 1'b1);
        issue(ACT_WRITE, THEME_ONE,  8'hFF, 16'hFFFF, 1'b1);
        issue(ACT_QUERY, THEME_ZERO, 8'h00, 16'h0000, 1'b0);
        // rejected theme numbers
        issue(ACT_WRITE, THEME_BAD_LO, 8'h02, 16'h1234, 1'b0);
        issue(ACT_WRITE, THEME_BAD_HI, 8'h02, 16'hFFFF, 1'b1);
        // chain 5 -> 4 -> 3 -> 2 -> 1 -> direct, a self loop, a path to zero
        issue(ACT_WRITE, THEME_ZERO, 8'h02, 16'h0101, 1'b0);
        issue(ACT_WRITE, THEME_ZERO, 8'h03, 16'h7F02, 1'b0);
        issue(ACT_WRITE, THEME_ZERO, 8'h04, 16'h0003, 1'b0);
        issue(ACT_WRITE, THEME_ZERO, 8'h05, 16'h0004, 1'b0);
        issue(ACT_WRITE, THEME_ZERO, 8'h06, 16'h0006, 1'b0);
        issue(ACT_WRITE, THEME_ZERO, 8'h00, 16'h0000, 1'b0);
        issue(ACT_WRITE, THEME_ZERO, 8'h07, 16'h0100, 1'b0);
        // direct colour, zero, longest legal chain, too long, loop, zero entry
        issue(ACT_RESOLVE, THEME_ZERO, 8'h00, 16'hFFFF, 1'b0);
        issue(ACT_RESOLVE, THEME_ZERO, 8'h00, 16'h0000, 1'b0);
        issue(ACT_RESOLVE, THEME_ZERO, 8'h00, 16'h7F04, 1'b0);
        issue(ACT_RESOLVE, THEME_ZERO, 8'h00, 16'h0005, 1'b0);
        issue(ACT_RESOLVE, THEME_ZERO, 8'h00, 16'h0006, 1'b0);
        issue(ACT_RESOLVE, THEME_ZERO, 8'h00, 16'h0007, 1'b0);
        // select: rejected, same theme, other theme; then resolve there and toggle back
        issue(ACT_SELECT, THEME_BAD_HI, 8'h00, 16'h0000, 1'b0);
        issue(ACT_SELECT, THEME_ZERO,   8'h00, 16'h0000, 1'b0);
        issue(ACT_SELECT, THEME_ONE,    8'h00, 16'h0000, 1'b0);
        issue(ACT_RESOLVE, THEME_ZERO,  8'h00, 16'h00FF, 1'b0);
        issue(ACT_TOGGLE, THEME_ZERO,   8'h00, 16'h0000, 1'b0);
        // spare codes change nothing, clear included
        issue(ACT_SPARE_FIRST, THEME_ZERO,   8'h00, 16'h0000, 1'b0);
        issue(ACT_SPARE_LAST,  THEME_BAD_HI, 8'hFF, 16'hFFFF, 1'b1);

        // random words, with a stretch where neither side idles
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            calm = (n >= 500 && n < 700);
            k    = $urandom_range(0, 99);
            th   = 2'($urandom_range(0, 3));
            if (k < 40)
                act = ACT_RESOLVE;
            else if (k < 72)
            begin
                act = ACT_WRITE;
                if ($urandom_range(0, 9) != 0)
                    th = {1'b0, th[0]};
            end
            else if (k < 80)
                act = ACT_SELECT;
            else if (k < 86)
                act = ACT_TOGGLE;
            else if (k < 97)
                act = ACT_QUERY;
            else
                act = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
            issue(act, th, pick_index(), pick_word(), 1'($urandom_range(0, 1)));
        end
        calm = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;

        // drain
        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (tracker.failures == 0 && tracker.awaited.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
rtl/core/tpr_pkg.sv
rtl/core/tpr_ram.sv
rtl/core/tpr_datapath.sv
rtl/core/tpr_ctrl.sv
rtl/core/themed_palette_resolver.sv
tb/tb_themed_palette_resolver.sv
